// ===== rtl/core/byte_fold_mersenne31_hash_top_macros.svh =====
// ------------------------------------------------------------------
// Assertion macros for the byte-fold hash core
// Shared clocked assertion forms, with and without reset masking.
// ------------------------------------------------------------------
`ifndef BYTE_FOLD_MERSENNE31_HASH_TOP_MACROS_SVH
`define BYTE_FOLD_MERSENNE31_HASH_TOP_MACROS_SVH

// checked only while out of reset
`define BF31_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BF31_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bf31_pkg.sv =====
// ------------------------------------------------------------------
// bf31_pkg
// Types and constants shared by the byte-fold hash modules.
// ------------------------------------------------------------------
package bf31_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int LANE_W = 2;
  localparam int HASH_W = 31;
  localparam int PROD_W = 2 * WORD_W;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT_COEF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_COEF  = 1'b1;

  localparam logic [WORD_W-1:0] MULT_COEF_RST = 32'd1;
  localparam logic [WORD_W-1:0] ADD_COEF_RST  = 32'd0;

  // folded word handed to the hash pipeline
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] word;
  } fold_beat_t;

endpackage

// ===== rtl/core/bf31_fold.sv =====
// ------------------------------------------------------------------
// bf31_fold
// Packs bytes little-endian into words and keeps the running sum.
// ------------------------------------------------------------------
`include "byte_fold_mersenne31_hash_top_macros.svh"

module bf31_fold (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_acc,
  input  logic [bf31_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         segment_start,
  input  logic                         last_byte,
  output bf31_pkg::fold_beat_t         fold_out
);

  logic [bf31_pkg::WORD_W-1:0] sum_r, sum_nxt;
  logic [bf31_pkg::LANE_W-1:0] lane_r, lane_nxt;
  logic [bf31_pkg::LANE_W-1:0] lane_cur;
  logic [bf31_pkg::WORD_W-1:0] addend;
  logic [bf31_pkg::WORD_W-1:0] folded;
  bf31_pkg::fold_beat_t        beat_r, beat_nxt;

  assign lane_cur = segment_start ? '0 : lane_r;

  always_comb begin
    case (lane_cur)
      2'd0:    addend = {24'd0, data_byte};
      2'd1:    addend = {16'd0, data_byte, 8'd0};
      2'd2:    addend = {8'd0, data_byte, 16'd0};
      default: addend = {data_byte, 24'd0};
    endcase
  end

  assign folded = sum_r + addend;

  always_comb begin
    sum_nxt  = sum_r;
    lane_nxt = lane_r;
    beat_nxt = beat_r;
    if (adv) begin
      beat_nxt.vld  = in_acc && last_byte;
      beat_nxt.word = folded;
    end
    if (in_acc) begin
      if (last_byte) begin
        sum_nxt  = '0;
        lane_nxt = '0;
      end else begin
        sum_nxt  = folded;
        lane_nxt = lane_cur + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      lane_r     <= '0;
      beat_r.vld <= 1'b0;
    end else begin
      sum_r      <= sum_nxt;
      lane_r     <= lane_nxt;
      beat_r.vld <= beat_nxt.vld;
    end
    beat_r.word <= beat_nxt.word;
  end

  assign fold_out = beat_r;

  `BF31_ASSERT(a_last_clears, in_acc && last_byte |=> sum_r == '0 && lane_r == '0, "sum not cleared after last beat")
  `BF31_ASSERT(a_start_lane, in_acc && segment_start && !last_byte |=> lane_r == 2'd1, "segment start did not realign lane")

endmodule

// ===== rtl/core/bf31_mulred.sv =====
// ------------------------------------------------------------------
// bf31_mulred
// Hash pipeline: multiply, add, Mersenne 2^31-1 fold, output register.
// ------------------------------------------------------------------
`include "byte_fold_mersenne31_hash_top_macros.svh"

module bf31_mulred (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [bf31_pkg::WORD_W-1:0]   mult_coef,
  input  logic [bf31_pkg::WORD_W-1:0]   add_coef,
  input  bf31_pkg::fold_beat_t          fold_in,
  output logic                          hash_vld,
  output logic [bf31_pkg::HASH_W-1:0]   hash_value
);

  logic                          p_vld_r, r_vld_r, o_vld_r;
  logic [bf31_pkg::PROD_W-1:0]   p_r, r_r;
  logic [bf31_pkg::HASH_W-1:0]   o_r;
  logic [bf31_pkg::PROD_W-1:0]   p_nxt;
  logic [bf31_pkg::PROD_W-1:0]   r_nxt;
  logic [bf31_pkg::HASH_W-1:0]   o_nxt;

  // 32x32 product, operands zero-extended so the full 64 bits are kept
  assign p_nxt = {{(bf31_pkg::PROD_W-bf31_pkg::WORD_W){1'b0}}, mult_coef} *
                 {{(bf31_pkg::PROD_W-bf31_pkg::WORD_W){1'b0}}, fold_in.word};
  assign r_nxt = p_r + {{(bf31_pkg::PROD_W-bf31_pkg::WORD_W){1'b0}}, add_coef};
  // low 31 bits of (r >> 31) + r
  assign o_nxt = r_r[2*bf31_pkg::HASH_W-1:bf31_pkg::HASH_W] + r_r[bf31_pkg::HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= fold_in.vld;
      r_vld_r <= p_vld_r;
      o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
      r_r <= r_nxt;
      o_r <= o_nxt;
    end
  end

  assign hash_vld   = o_vld_r;
  assign hash_value = o_r;

  `BF31_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !o_vld_r, "output valid after reset")
  `BF31_ASSERT(a_no_phantom, !o_vld_r && !r_vld_r |=> !o_vld_r, "result without an item in flight")

endmodule

// ===== rtl/core/byte_fold_mersenne31_hash_top.sv =====
// ------------------------------------------------------------------
// byte_fold_mersenne31_hash_top
// Byte-fold word sum hashed as (a*x+b) mod-folded to 31 bits.
// ------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | tdata[7:0] data byte, tuser segment start, tlast last byte
// out_    | out | tdata[30:0] hash value, bit 31 zero
// cfg_    | in  | index 0 mult_coef, index 1 add_coef, 32-bit data
//
// One byte per cycle unless out_ stalls; a hash passes the fold beat,
// product, sum and output registers after its last byte; the fold add sets
// the rate. Multiply, add and fold each take one pipeline register.
// Synchronous active-low reset clears sum, lane and all valid flags;
// coefficients reset to a=1, b=0.
// An output stall freezes the whole pipe and drops in_tready.
// ------------------------------------------------------------------
module byte_fold_mersenne31_hash_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic [0:0]                       in_tuser,   // [0] segment_start
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [30:0] hash_value
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bf31_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf31_pkg::WORD_W-1:0]      cfg_data
);

  logic                          adv;
  logic                          in_acc;
  logic [bf31_pkg::WORD_W-1:0]   mult_coef_r, add_coef_r;
  bf31_pkg::fold_beat_t          fold_beat;
  logic                          hash_vld;
  logic [bf31_pkg::HASH_W-1:0]   hash_value;

  assign adv       = !hash_vld || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_coef_r <= bf31_pkg::MULT_COEF_RST;
      add_coef_r  <= bf31_pkg::ADD_COEF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bf31_pkg::REG_MULT_COEF: mult_coef_r <= cfg_data;
        bf31_pkg::REG_ADD_COEF:  add_coef_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  bf31_fold u_fold (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_acc        (in_acc),
    .data_byte     (in_tdata),
    .segment_start (in_tuser[0]),
    .last_byte     (in_tlast),
    .fold_out      (fold_beat)
  );

  bf31_mulred u_mulred (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .mult_coef  (mult_coef_r),
    .add_coef   (add_coef_r),
    .fold_in    (fold_beat),
    .hash_vld   (hash_vld),
    .hash_value (hash_value)
  );

  assign out_tvalid = hash_vld;
  assign out_tdata  = {1'b0, hash_value};

endmodule

// ===== dv/tb_byte_fold_mersenne31_hash_top.sv =====
// ------------------------------------------------------------------
// tb_byte_fold_mersenne31_hash_top
// Streams bytes into the byte-fold hash and checks every 31-bit hash
// against a cycle-free predictor of the fold and the (a*x+b) reduction.
// Covers directed corner messages, random keyed and unkeyed messages,
// several coefficient settings, random idling on both sides and one
// long output hold-off that backs up the input.
// ------------------------------------------------------------------
module tb_byte_fold_mersenne31_hash_top;

  typedef struct packed {
    logic [bf31_pkg::BYTE_W-1:0] data;
    logic                        seg;
    logic                        lst;
  } byte_beat_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;   // [7:0] data_byte
  logic [0:0]                     in_tuser = '0;   // [0] segment_start
  logic                           in_tlast = 1'b0; // last_byte
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;       // [30:0] hash_value, [31] zero
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bf31_pkg::CFG_IDX_W-1:0] cfg_index = bf31_pkg::REG_MULT_COEF;
  logic [bf31_pkg::WORD_W-1:0]    cfg_data = '0;

  byte_beat_t                     byte_q[$];
  logic [bf31_pkg::HASH_W-1:0]    pending_hash_q[$];

  // predictor state
  logic [bf31_pkg::WORD_W-1:0]    coef_a = bf31_pkg::MULT_COEF_RST;
  logic [bf31_pkg::WORD_W-1:0]    coef_b = bf31_pkg::ADD_COEF_RST;
  logic [bf31_pkg::WORD_W-1:0]    sum_acc = '0;
  logic [bf31_pkg::LANE_W-1:0]    lane_acc = '0;

  bit                   in_beat_done = 1'b0;
  bit                   tx_idle = 1'b0;
  bit                   rx_idle = 1'b0;
  logic                 rx_hold = 1'b0;
  int unsigned          tx_gap = 0;
  int unsigned          rx_stall = 0;
  int unsigned          n_bytes = 0;
  int unsigned          n_hashes = 0;
  int unsigned          n_settings = 0;
  int unsigned          n_errors = 0;

  byte_fold_mersenne31_hash_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_wait(input bit enable);
    if (!enable || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [bf31_pkg::HASH_W-1:0] mersenne_fold(
      input logic [bf31_pkg::WORD_W-1:0] a,
      input logic [bf31_pkg::WORD_W-1:0] b,
      input logic [bf31_pkg::WORD_W-1:0] x);
    logic [bf31_pkg::PROD_W-1:0] r;
    r = {32'd0, a} * {32'd0, x} + {32'd0, b};
    // carry out of bit 63 is dropped; only the low 31 bits survive anyway
    r = (r >> 31) + r;
    return r[bf31_pkg::HASH_W-1:0];
  endfunction

  task automatic fold_byte(input logic [bf31_pkg::BYTE_W-1:0] data, input logic seg,
                           input logic lst);
    if (seg) lane_acc = '0;
    sum_acc = sum_acc + ({24'd0, data} << {lane_acc, 3'b000});
    lane_acc = lane_acc + 1'b1;
    if (lst) begin
      pending_hash_q.push_back(mersenne_fold(coef_a, coef_b, sum_acc));
      sum_acc = '0;
      lane_acc = '0;
    end
  endtask

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // input driver
  always @(negedge clk) begin
    byte_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_beat_done) begin
      // beat still waiting for tready
    end else if (tx_gap != 0) begin
      tx_gap--;
      in_tvalid <= 1'b0;
    end else if (byte_q.size() != 0) begin
      beat = byte_q.pop_front();
      in_tdata  <= beat.data;
      in_tuser  <= beat.seg;
      in_tlast  <= beat.lst;
      in_tvalid <= 1'b1;
      tx_gap = draw_wait(tx_idle);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // output ready driver
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on accepted inputs, check accepted outputs
  always @(posedge clk) begin
    logic [bf31_pkg::HASH_W-1:0] exp_hash;
    in_beat_done = in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bf31_pkg::REG_MULT_COEF: coef_a = cfg_data;
          bf31_pkg::REG_ADD_COEF:  coef_b = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        n_hashes++;
        if (pending_hash_q.size() == 0) begin
          note_error($sformatf("unexpected hash beat 0x%08h", out_tdata));
        end else begin
          exp_hash = pending_hash_q.pop_front();
          if (out_tdata !== {1'b0, exp_hash})
            note_error($sformatf("hash_value expected 0x%08h got 0x%08h",
                                 {1'b0, exp_hash}, out_tdata));
        end
        rx_stall = draw_wait(rx_idle);
      end
      if (in_beat_done) begin
        n_bytes++;
        fold_byte(in_tdata, in_tuser[0], in_tlast);
      end
    end
  end

  // long output hold-off while input keeps coming, to back up the pipe
  initial begin
    while (!(n_bytes >= 300 && byte_q.size() > 60)) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("byte_fold_mersenne31_hash_top test failed");
    $finish;
  end

  task automatic push_byte(input logic [7:0] data, input logic seg, input logic lst);
    byte_q.push_back('{data: data, seg: seg, lst: lst});
  endtask

  task automatic wait_idle;
    while (byte_q.size() != 0 || in_tvalid || pending_hash_q.size() != 0) @(posedge clk);
    // last bytes without tlast may still be inside the pipe
    repeat (8) @(posedge clk);
  endtask

  task automatic write_coef(input logic [bf31_pkg::CFG_IDX_W-1:0] idx,
                            input logic [bf31_pkg::WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_coefs(input logic [bf31_pkg::WORD_W-1:0] a,
                           input logic [bf31_pkg::WORD_W-1:0] b);
    wait_idle();
    write_coef(bf31_pkg::REG_MULT_COEF, a);
    write_coef(bf31_pkg::REG_ADD_COEF, b);
    n_settings++;
  endtask

  // random message: optional key segment, stray segment starts, rare long runs
  task automatic queue_message(output int unsigned len);
    int unsigned key_len;
    bit          keyed;
    logic        seg;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    keyed = $urandom_range(0, 1) == 1;
    key_len = $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      seg = (i == 0 && $urandom_range(0, 3) != 0) || (keyed && i == key_len) ||
            ($urandom_range(0, 15) == 0);
      push_byte(8'($urandom_range(0, 255)), seg, i == len - 1);
    end
  endtask

  task automatic queue_noise(output int unsigned len);
    len = $urandom_range(1, 6);
    for (int unsigned i = 0; i < len; i++)
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1,
                $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [bf31_pkg::WORD_W-1:0] set_a[8];
    logic [bf31_pkg::WORD_W-1:0] set_b[8];
    int unsigned                 queued;
    int unsigned                 len;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset coefficients (a=1, b=0)
    n_settings = 1;
    push_byte(8'hFF, 1'b1, 1'b1);                 // start and last together
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b0);                 // all-ones word folds to zero
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    for (int i = 1; i <= 5; i++)                  // lane wraps after lane 3
      push_byte(i[7:0], i == 1, i == 5);
    push_byte(8'hAA, 1'b1, 1'b0);                 // key, then realigned message
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b1);

    // directed, largest coefficients: reduction carry
    set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++)
      push_byte(8'hFF, i == 0, i == 3);
    push_byte(8'h00, 1'b1, 1'b1);

    set_a = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h7FFF_FFFF,
              $urandom, $urandom, $urandom};
    set_b = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
              $urandom, $urandom, $urandom};

    for (int p = 0; p < 8; p++) begin
      set_coefs(set_a[p], set_b[p]);
      tx_idle = (p % 3) != 0;
      rx_idle = (p % 4) != 1;
      queued = 0;
      while (queued < 135) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_noise(len);
          queued += len;
        end
        queue_message(len);
        queued += len;
      end
    end

    while (byte_q.size() != 0 || in_tvalid || pending_hash_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_hash_q.size() != 0)
      note_error($sformatf("%0d hashes never arrived", pending_hash_q.size()));

    $display("Run covered %0d input bytes and %0d hash beats over %0d coefficient settings,",
             n_bytes, n_hashes, n_settings);
    $display("with keyed segments, lane wraps, idle gaps and one long output hold-off.");
    if (n_errors == 0) begin
      $display("byte_fold_mersenne31_hash_top test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("byte_fold_mersenne31_hash_top test failed");
    end
    $finish;
  end

endmodule
